>>> hdl/qrr_pkg.sv
// Shared constants, types and command codes for the rational quadratic root solver.
package qrr_pkg;

    localparam int COEF_WIDTH  = 16;
    localparam int NUM_WIDTH   = 18;
    localparam int DEN_WIDTH   = 17;
    localparam int STATUS_W    = 2;
    localparam int PROD_W      = 2 * COEF_WIDTH;
    localparam int DISC_W      = 2 * COEF_WIDTH + 3;
    localparam int SQ_W        = 2 * COEF_WIDTH + 2;
    localparam int MAG_W       = COEF_WIDTH + 1;
    localparam int NW          = MAG_W + 2;
    localparam int K_W         = $clog2(MAG_W + 1);
    localparam int CNT_W       = $clog2(MAG_W);
    localparam int IN_TDATA_W  = ((3 * COEF_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 2 * NUM_WIDTH + 2 * DEN_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK, ST_A_ZERO, ST_DISC_NEG, ST_IRRATIONAL
    } t_status;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_MUL_BB, OP_MUL_AC, OP_DISC, OP_SQRT,
        OP_ROOT, OP_GCD, OP_DIV_INIT, OP_DIV, OP_STORE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic minus;
        logic den;
    } t_cmd;

    typedef struct packed {
        logic a_zero;
        logic disc_neg;
        logic sqrt_last;
        logic not_square;
        logic gcd_done;
        logic div_last;
    } t_dp_stat;

endpackage

>>> hdl/qrr_dp.sv
// Datapath: discriminant, bit-serial square root, binary gcd and restoring divider.
module qrr_dp import qrr_pkg::*; (
    input  logic                         i_clk,
    input  t_cmd                         i_cmd,
    input  logic signed [COEF_WIDTH-1:0] i_coef_a,
    input  logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  logic signed [COEF_WIDTH-1:0] i_coef_c,
    output t_dp_stat                     o_stat,
    output logic signed [NUM_WIDTH-1:0]  o_plus_num,
    output logic        [DEN_WIDTH-1:0]  o_plus_den,
    output logic signed [NUM_WIDTH-1:0]  o_minus_num,
    output logic        [DEN_WIDTH-1:0]  o_minus_den
);

    logic signed [COEF_WIDTH-1:0] r_a, r_b, r_c;
    logic signed [PROD_W-1:0]     r_bb, r_ac;
    logic                         r_disc_neg;
    logic [SQ_W-1:0]              r_x, r_res, r_bit;
    logic [MAG_W-1:0]             r_mn, r_md, r_u, r_v, r_g, r_q;
    logic [K_W-1:0]               r_k;
    logic                         r_neg;
    logic [MAG_W:0]               r_rem;
    logic [CNT_W-1:0]             r_cnt;
    logic signed [NUM_WIDTH-1:0]  r_pn, r_mnum;
    logic [DEN_WIDTH-1:0]         r_pd, r_mden;

    logic signed [DISC_W-1:0] disc, ac_ext;
    logic [SQ_W-1:0]          sq_sum;
    logic signed [NW-1:0]     rr, nb, n, d;
    logic [MAG_W+1:0]         trial;
    logic [MAG_W:0]           shifted;
    logic signed [MAG_W:0]    qs, num;

    always_comb begin
        ac_ext  = DISC_W'(r_ac);
        disc    = DISC_W'(r_bb) - (ac_ext <<< 2);
        sq_sum  = r_res + r_bit;
        rr      = NW'(signed'({1'b0, r_res[MAG_W-1:0]}));
        nb      = -NW'(r_b);
        n       = i_cmd.minus ? (nb - rr) : (nb + rr);
        d       = NW'(r_a) <<< 1;
        shifted = {r_rem[MAG_W-1:0], r_q[MAG_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_g};
        qs      = signed'({1'b0, r_q});
        num     = r_neg ? -qs : qs;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_a    <= i_coef_a;
                r_b    <= i_coef_b;
                r_c    <= i_coef_c;
                r_pn   <= '0;
                r_pd   <= '0;
                r_mnum <= '0;
                r_mden <= '0;
            end
            OP_MUL_BB: r_bb <= r_b * r_b;
            OP_MUL_AC: r_ac <= r_a * r_c;
            OP_DISC: begin
                r_disc_neg <= disc[DISC_W-1];
                r_x        <= disc[SQ_W-1:0];
                r_res      <= '0;
                r_bit      <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_SQRT: begin
                if (r_x >= sq_sum) begin
                    r_x   <= r_x - sq_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_ROOT: begin
                r_mn  <= MAG_W'(n[NW-1] ? -n : n);
                r_md  <= MAG_W'(d[NW-1] ? -d : d);
                r_u   <= MAG_W'(n[NW-1] ? -n : n);
                r_v   <= MAG_W'(d[NW-1] ? -d : d);
                r_k   <= '0;
                r_neg <= n[NW-1] ^ d[NW-1];
            end
            OP_GCD: begin
                if (r_u == '0 || r_v == '0) begin
                    r_g <= (r_u | r_v) << r_k;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + K_W'(1);
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u >= r_v) begin
                    r_u <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
            OP_DIV_INIT: begin
                r_q   <= i_cmd.den ? r_md : r_mn;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV: begin
                if (!trial[MAG_W+1]) begin
                    r_rem <= trial[MAG_W:0];
                    r_q   <= {r_q[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_q   <= {r_q[MAG_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
            OP_STORE: begin
                case ({i_cmd.minus, i_cmd.den})
                    2'b00:   r_pn   <= NUM_WIDTH'(num);
                    2'b01:   r_pd   <= DEN_WIDTH'(r_q);
                    2'b10:   r_mnum <= NUM_WIDTH'(num);
                    default: r_mden <= DEN_WIDTH'(r_q);
                endcase
            end
            default: ;
        endcase
    end

    assign o_stat.a_zero     = (r_a == '0);
    assign o_stat.disc_neg   = r_disc_neg;
    assign o_stat.sqrt_last  = (r_bit == SQ_W'(1));
    assign o_stat.not_square = (r_x != '0);
    assign o_stat.gcd_done   = (r_u == '0) || (r_v == '0);
    assign o_stat.div_last   = (r_cnt == CNT_W'(MAG_W - 1));
    assign o_plus_num  = r_pn;
    assign o_plus_den  = r_pd;
    assign o_minus_num = r_mnum;
    assign o_minus_den = r_mden;

endmodule

>>> hdl/qrr_ctrl.sv
// Controller: sequences the datapath through one item and reports its status.
module qrr_ctrl import qrr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output logic     o_ready,
    output logic     o_done,
    output t_status  o_status,
    output t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_BB, S_MUL_AC, S_DISC, S_CHK, S_SQRT, S_SQCHK, S_ROOT,
        S_GCD, S_DIVN_INIT, S_DIVN, S_STN, S_DIVD_INIT, S_DIVD, S_STD, S_FIN
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_minus, n_minus;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_minus  = r_minus;
        o_cmd    = '{op: OP_NOP, minus: r_minus, den: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_MUL_BB;
                end
            end
            S_MUL_BB: begin
                o_cmd.op = OP_MUL_BB;
                n_state  = S_MUL_AC;
            end
            S_MUL_AC: begin
                o_cmd.op = OP_MUL_AC;
                n_state  = S_DISC;
            end
            S_DISC: begin
                if (i_stat.a_zero) begin
                    n_status = ST_A_ZERO;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_DISC;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.disc_neg) begin
                    n_status = ST_DISC_NEG;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_stat.sqrt_last) n_state = S_SQCHK;
            end
            S_SQCHK: begin
                n_minus = 1'b0;
                if (i_stat.not_square) begin
                    n_status = ST_IRRATIONAL;
                    n_state  = S_FIN;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT;
                n_state  = S_GCD;
            end
            S_GCD: begin
                o_cmd.op = OP_GCD;
                if (i_stat.gcd_done) n_state = S_DIVN_INIT;
            end
            S_DIVN_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_state  = S_DIVN;
            end
            S_DIVN: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) n_state = S_STN;
            end
            S_STN: begin
                o_cmd.op = OP_STORE;
                n_state  = S_DIVD_INIT;
            end
            S_DIVD_INIT: begin
                o_cmd.op  = OP_DIV_INIT;
                o_cmd.den = 1'b1;
                n_state   = S_DIVD;
            end
            S_DIVD: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) n_state = S_STD;
            end
            S_STD: begin
                o_cmd.op  = OP_STORE;
                o_cmd.den = 1'b1;
                if (r_minus) begin
                    n_state = S_FIN;
                end else begin
                    n_minus = 1'b1;
                    n_state = S_ROOT;
                end
            end
            S_FIN: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_minus  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_minus  <= n_minus;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_done   = (r_state == S_FIN) && i_out_free;
    assign o_status = r_status;

endmodule

>>> hdl/quadratic_rational_roots.sv
// Top level of the rational quadratic root solver: stream ports and output register.
//
// Slave channel: one transfer carries coef_a, coef_b, coef_c (16-bit two's
// complement each). Master channel: one transfer per input with the status
// in tuser and the four reduced root fields in tdata.
// An item with a zero a or a negative discriminant ends before the square
// root, and one with an irrational root ends right after it. Rational roots
// take 17 square-root steps, then per root a binary gcd and two 17-step
// restoring divisions, all in one shared datapath.
// Throughput: one item at a time; a new item is taken in the cycle after the
// previous result has moved into the output register.
// Reset clears the controller and the output valid; no clearing pass.
// When the receiver stalls, the result holds in the output register and the
// next item is accepted and computed; it waits at its end until the register
// frees.
module quadratic_rational_roots import qrr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // coef_a, coef_b, coef_c
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // plus_numerator, plus_denominator, minus_numerator, minus_denominator, pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]    o_m_axis_tuser
);

    t_cmd                        cmd;
    t_dp_stat                    stat;
    t_status                     status;
    logic                        done, out_free;
    logic signed [NUM_WIDTH-1:0] pn, mn;
    logic        [DEN_WIDTH-1:0] pd, md;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0]    r_out_user;

    assign out_free = !r_out_valid || i_m_axis_tready;

    qrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ready    (o_s_axis_tready),
        .o_done     (done),
        .o_status   (status),
        .o_cmd      (cmd)
    );

    qrr_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_coef_a    (i_s_axis_tdata[COEF_WIDTH-1:0]),
        .i_coef_b    (i_s_axis_tdata[2*COEF_WIDTH-1:COEF_WIDTH]),
        .i_coef_c    (i_s_axis_tdata[3*COEF_WIDTH-1:2*COEF_WIDTH]),
        .o_stat      (stat),
        .o_plus_num  (pn),
        .o_plus_den  (pd),
        .o_minus_num (mn),
        .o_minus_den (md)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= OUT_TDATA_W'({md, mn, pd, pn});
            r_out_user <= status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

>>> hdl/qrr_checker.sv
// Port-level checks for the rational quadratic root solver, bound to the top level.
module qrr_checker import qrr_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [STATUS_W-1:0]    o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item taken while busy");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_OK |-> o_m_axis_tdata == '0)
        else $error("error result carries roots");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_OK |->
            o_m_axis_tdata[NUM_WIDTH+DEN_WIDTH-1:NUM_WIDTH] != '0 &&
            o_m_axis_tdata[OUT_FIELD_W-1:2*NUM_WIDTH+DEN_WIDTH] != '0)
        else $error("zero denominator on success");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not idle after reset");

endmodule

bind quadratic_rational_roots qrr_checker u_qrr_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the rational quadratic root solver stream block.
module tb_top;
    import qrr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
    } t_coefs;

    typedef struct {
        t_status            status;
        logic [NUM_WIDTH-1:0] pn;
        logic [DEN_WIDTH-1:0] pd;
        logic [NUM_WIDTH-1:0] mn;
        logic [DEN_WIDTH-1:0] md;
    } t_roots;

    typedef struct {
        t_coefs coefs;
        logic   typed;
        t_roots roots;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]    o_m_axis_tuser;

    t_roots pending_roots[$];
    int     errors = 0;
    int     cycles = 0;
    bit     feeding_done = 0;
    bit     hold_off = 0;

    quadratic_rational_roots dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 10000000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic void lowest_terms(longint n, longint d,
                                         output logic [NUM_WIDTH-1:0] on,
                                         output logic [DEN_WIDTH-1:0] od);
        longint unsigned mn, md, g;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        g = gcd_of(mn, md);
        if (g == 0) g = 1;
        mn = mn / g;
        md = md / g;
        if ((n < 0) != (d < 0)) mn = -mn;
        on = mn[NUM_WIDTH-1:0];
        od = md[DEN_WIDTH-1:0];
    endfunction

    function automatic t_roots solve_roots(t_coefs k);
        t_roots res;
        longint a, b, c, disc, r;
        a = k.a;
        b = k.b;
        c = k.c;
        res = '{ST_OK, '0, '0, '0, '0};
        if (a == 0) begin
            res.status = ST_A_ZERO;
            return res;
        end
        disc = b * b - 4 * a * c;
        if (disc < 0) begin
            res.status = ST_DISC_NEG;
            return res;
        end
        r = longint'($floor($sqrt(real'(disc))));
        while (r * r > disc) r--;
        while ((r + 1) * (r + 1) <= disc) r++;
        if (r * r != disc) begin
            res.status = ST_IRRATIONAL;
            return res;
        end
        lowest_terms(-b + r, 2 * a, res.pn, res.pd);
        lowest_terms(-b - r, 2 * a, res.mn, res.md);
        return res;
    endfunction

    function automatic t_coefs random_coefs();
        t_coefs k;
        int p, q, s, t, m;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                k = t_coefs'(48'({$urandom, $urandom}));
            end
            3: begin
                k.a = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
                k.b = 16'($urandom);
                k.c = 16'($urandom_range(0, 15)) - 16'sd8;
            end
            default: begin
                // build (p x + q)(s x + t) with small factors so roots are rational
                m = $urandom_range(0, 3) == 0 ? 180 : 15;
                p = $urandom_range(1, m) * ($urandom_range(0, 1) ? 1 : -1);
                s = $urandom_range(1, m) * ($urandom_range(0, 1) ? 1 : -1);
                q = int'($urandom_range(0, 2 * m)) - m;
                t = int'($urandom_range(0, 2 * m)) - m;
                k.a = 16'(p * s);
                k.b = 16'(p * t + q * s);
                k.c = 16'(q * t);
            end
        endcase
        return k;
    endfunction

    task automatic send_item(t_coefs k);
        while ($urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 200) : 1) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {k.c, k.b, k.a};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_roots.push_back(solve_roots(k));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_roots want, got;
            got.status = t_status'(o_m_axis_tuser);
            {got.md, got.mn, got.pd, got.pn} = o_m_axis_tdata[OUT_FIELD_W-1:0];
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, got.status);
                errors++;
            end else begin
                want = pending_roots.pop_front();
                if (got.status != want.status || got.pn != want.pn || got.pd != want.pd
                    || got.mn != want.mn || got.md != want.md) begin
                    $display("%0t: mismatch expected %0d %h/%h %h/%h got %0d %h/%h %h/%h",
                             $time, want.status, want.pn, want.pd, want.mn, want.md,
                             got.status, got.pn, got.pd, got.mn, got.md);
                    errors++;
                end
            end
        end
    end

    initial begin
        @(posedge i_clk);
        while (!feeding_done) begin
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300) : 1)
                    @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8) == 1 ? $urandom_range(50, 400) : 1)
                    @(posedge i_clk);
            end
        end
        i_m_axis_tready <= 1'b1;
    end

    initial begin
        t_row table_rows[$];
        t_roots got_roots;
        got_roots = '{ST_OK, 0, 0, 0, 0};
        table_rows.push_back('{'{16'sd0, 16'sd5, 16'sd3}, 1, '{ST_A_ZERO, 0, 0, 0, 0}});
        table_rows.push_back('{'{16'sd1, 16'sd0, 16'sd1}, 1, '{ST_DISC_NEG, 0, 0, 0, 0}});
        table_rows.push_back('{'{16'sd1, 16'sd0, -16'sd2}, 1, '{ST_IRRATIONAL, 0, 0, 0, 0}});
        table_rows.push_back('{'{16'sd1, -16'sd3, 16'sd2}, 1, '{ST_OK, 2, 1, 1, 1}});
        table_rows.push_back('{'{16'sd1, 16'sd0, 16'sd0}, 1, '{ST_OK, 0, 1, 0, 1}});
        table_rows.push_back('{'{16'sd4, 16'sd4, 16'sd1}, 0, got_roots});
        table_rows.push_back('{'{-16'sd2, 16'sd3, 16'sd2}, 0, got_roots});
        table_rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd0}, 0, got_roots});
        table_rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd0}, 0, got_roots});
        table_rows.push_back('{'{-16'sd32768, -16'sd32768, 16'sd0}, 0, got_roots});
        table_rows.push_back('{'{16'sd1, -16'sd32768, 16'sd0}, 0, got_roots});
        table_rows.push_back('{'{16'sd1, 16'sd0, -16'sd32768}, 0, got_roots});
        table_rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd32767}, 0, got_roots});
        table_rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768}, 0, got_roots});
        table_rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767}, 0, got_roots});
        table_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1, '{ST_A_ZERO, 0, 0, 0, 0}});
        table_rows.push_back('{'{-16'sd1, -16'sd1, -16'sd1}, 0, got_roots});
        table_rows.push_back('{'{16'sd1, 16'sd0, -16'sd16384}, 0, got_roots});
        table_rows.push_back('{'{-16'sd1, 16'sd0, 16'sd16384}, 0, got_roots});
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[i]) begin
            send_item(table_rows[i].coefs);
            if (table_rows[i].typed) begin
                pending_roots.pop_back();
                pending_roots.push_back(table_rows[i].roots);
            end
        end
        for (int n = 0; n < 1630; n++) begin
            if (n == 800) hold_off = 1;
            send_item(random_coefs());
        end
        i_s_axis_tvalid <= 1'b0;
        feeding_done = 1;
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

>>> sim.f
hdl/qrr_pkg.sv
hdl/qrr_dp.sv
hdl/qrr_ctrl.sv
hdl/quadratic_rational_roots.sv
hdl/qrr_checker.sv
tb/tb_top.sv
